[design/ldps_pkg.sv]
package ldps_pkg;

   // Width of every count field on the ports.
   localparam int FIELD_BITS = 20;
   // Fraction bits of the Q1.16 results.
   localparam int FRAC_BITS  = 16;
   // Quotient bits produced by each divider.
   localparam int QUOT_BITS  = 18;

   localparam logic [QUOT_BITS-1:0] D_LIMIT = 18'd16384;
   localparam logic [QUOT_BITS-1:0] Q_ONE   = 18'd65536;

   // Bit positions inside window_enables.
   localparam int WIN_MAX_MARKER = 0;
   localparam int WIN_MAX_BP     = 1;
   localparam int WIN_MIN_MARKER = 2;
   localparam int WIN_MIN_BP     = 3;

   typedef enum logic [2:0] {
      REG_NUM_HAPLOTYPES,
      REG_WINDOW_ENABLES,
      REG_MAX_MARKER_GAP,
      REG_MAX_BP_GAP,
      REG_MIN_MARKER_GAP,
      REG_MIN_BP_GAP,
      REG_MIN_R2
   } reg_index_type;

   typedef struct packed {
      logic [19:0] num_haplotypes;
      logic [3:0]  window_enables;
      logic [23:0] max_marker_gap;
      logic [30:0] max_bp_gap;
      logic [23:0] min_marker_gap;
      logic [30:0] min_bp_gap;
      logic [16:0] min_r2;
   } cfg_type;

   // Per-item flags that ride along the back pipeline.
   typedef struct packed {
      logic pass;
      logic degen;
      logic neg;
   } tag_type;

endpackage

[design/ldps_front.sv]
module ldps_front #(
   parameter int CW = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  ldps_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [19:0]         req_joint_count,
   input  logic [19:0]         req_count_first,
   input  logic [19:0]         req_count_second,
   input  logic [23:0]         req_marker_gap,
   input  logic [30:0]         req_bp_gap,
   output logic                push_valid,
   input  logic                push_ready,
   output logic [2+8*CW-1:0]   push_data
);
   import ldps_pkg::*;

   localparam int PW = 2 * CW;
   localparam int IW = 2 + 8 * CW;

   logic [CW-1:0] n, j, a, b, na, nb;
   logic [PW-1:0] jn, ab;
   logic          pass, degen;

   logic          front_valid_ff, front_valid_in;
   logic [IW-1:0] item_ff;

   assign n = cfg.num_haplotypes[CW-1:0];
   assign j = req_joint_count[CW-1:0];
   assign a = req_count_first[CW-1:0];
   assign b = req_count_second[CW-1:0];

   assign na = n - a;
   assign nb = n - b;
   assign jn = PW'(j) * PW'(n);
   assign ab = PW'(a) * PW'(b);

   always_comb begin
      pass = 1'b1;
      if (cfg.window_enables[WIN_MAX_MARKER] && req_marker_gap > cfg.max_marker_gap) begin
         pass = 1'b0;
      end
      if (cfg.window_enables[WIN_MAX_BP] && req_bp_gap > cfg.max_bp_gap) begin
         pass = 1'b0;
      end
      if (cfg.window_enables[WIN_MIN_MARKER] && req_marker_gap < cfg.min_marker_gap) begin
         pass = 1'b0;
      end
      if (cfg.window_enables[WIN_MIN_BP] && req_bp_gap < cfg.min_bp_gap) begin
         pass = 1'b0;
      end
   end

   // A marker is monomorphic when its count is zero or reaches N.
   assign degen = (a == '0) || (a >= n) || (b == '0) || (b >= n);

   assign req_ready  = !front_valid_ff || push_ready;
   assign push_valid = front_valid_ff;
   assign push_data  = item_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (req_ready) begin
         front_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= {pass, degen, jn, ab, a, b, na, nb};
      end
   end

endmodule

[design/ldps_queue.sv]
module ldps_queue #(
   parameter int WIDTH = 162
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import ldps_pkg::*;

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/ldps_divider.sv]
module ldps_divider #(
   parameter int NW = 56,
   parameter int DW = 40
) (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [NW-1:0]                  num,
   input  logic [DW-1:0]                  den,
   output logic [ldps_pkg::QUOT_BITS-1:0] quo
);
   import ldps_pkg::*;

   localparam int CMPW = (NW > DW + QUOT_BITS) ? NW : DW + QUOT_BITS;

   logic [NW-1:0]        rem_ff [QUOT_BITS];
   logic [DW-1:0]        den_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0] quo_ff [QUOT_BITS];

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar s = 0; s < QUOT_BITS; s++) begin : g_stage
      logic [NW-1:0]        rem_src, rem_in;
      logic [DW-1:0]        den_src;
      logic [QUOT_BITS-1:0] quo_src, quo_in;
      logic [CMPW-1:0]      shifted, rem_wide, diff;
      logic                 ge;

      if (s == 0) begin : g_head
         assign rem_src = num;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_body
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      assign shifted  = CMPW'(den_src) << (QUOT_BITS - 1 - s);
      assign rem_wide = CMPW'(rem_src);
      assign ge       = rem_wide >= shifted;
      assign diff     = rem_wide - shifted;
      assign rem_in   = ge ? diff[NW-1:0] : rem_src;
      assign quo_in   = {quo_src[QUOT_BITS-2:0], ge};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_src;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QUOT_BITS-1];

endmodule

[design/ldps_back.sv]
module ldps_back #(
   parameter int CW = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  ldps_pkg::cfg_type  cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  logic [2+8*CW-1:0]  pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_keep,
   output logic               rsp_degenerate,
   output logic [16:0]        rsp_r2_value,
   output logic signed [15:0] rsp_d_value,
   output logic signed [17:0] rsp_dprime_value
);
   import ldps_pkg::*;

   localparam int PW = 2 * CW;
   localparam int ZW = 4 * CW;

   logic          adv;
   logic          u_pass, u_degen;
   logic [PW-1:0] u_jn, u_ab;
   logic [CW-1:0] u_a, u_b, u_na, u_nb, n;

   // Stage 1: magnitude of the numerator and the allele-count products.
   logic          b1_valid_ff;
   tag_type       b1_tag_ff;
   logic [PW-1:0] b1_mag_ff, b1_nsq_ff, b1_ab_ff, b1_nn_ff, b1_anb_ff, b1_nab_ff;
   logic [PW-1:0] b1_va_ff, b1_vb_ff;

   // Stage 2: D' bound and partial products of the wide squares.
   logic          b2_valid_ff;
   tag_type       b2_tag_ff;
   logic [PW-1:0] b2_mag_ff, b2_nsq_ff, b2_dmax_ff;
   logic [PW-1:0] b2_mll_ff, b2_mlh_ff, b2_mhh_ff;
   logic [PW-1:0] b2_vll_ff, b2_vlh_ff, b2_vhl_ff, b2_vhh_ff;
   logic [PW-1:0] dp_x, dp_y;

   // Stage 3: summed squares ready for the dividers.
   logic          b3_valid_ff;
   tag_type       b3_tag_ff;
   logic [PW-1:0] b3_mag_ff, b3_nsq_ff, b3_dmax_ff;
   logic [ZW-1:0] b3_msq_ff, b3_den_ff;

   logic          div_valid_ff [QUOT_BITS];
   tag_type       div_tag_ff   [QUOT_BITS];

   logic [QUOT_BITS-1:0] q_d, q_dp, q_r2;
   logic [QUOT_BITS-1:0] d_sat, dp_sat, r2_sat;
   logic [16:0]          r2_res;

   logic                 out_valid_ff;
   logic                 out_keep_ff, out_degen_ff;
   logic [16:0]          out_r2_ff;
   logic [15:0]          out_d_ff;
   logic [17:0]          out_dp_ff;

   assign adv       = !out_valid_ff || rsp_ready;
   assign pop_ready = adv;
   assign n         = cfg.num_haplotypes[CW-1:0];

   assign {u_pass, u_degen, u_jn, u_ab, u_a, u_b, u_na, u_nb} = pop_data;

   assign dp_x = b1_tag_ff.neg ? b1_ab_ff : b1_anb_ff;
   assign dp_y = b1_tag_ff.neg ? b1_nn_ff : b1_nab_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < QUOT_BITS; i++) begin
            div_valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         b1_valid_ff     <= pop_valid;
         b2_valid_ff     <= b1_valid_ff;
         b3_valid_ff     <= b2_valid_ff;
         div_valid_ff[0] <= b3_valid_ff;
         for (int i = 1; i < QUOT_BITS; i++) begin
            div_valid_ff[i] <= div_valid_ff[i-1];
         end
         out_valid_ff <= div_valid_ff[QUOT_BITS-1];
      end

      if (adv) begin
         b1_tag_ff.pass  <= u_pass;
         b1_tag_ff.degen <= u_degen;
         b1_tag_ff.neg   <= (u_jn < u_ab);
         b1_mag_ff       <= (u_jn >= u_ab) ? (u_jn - u_ab) : (u_ab - u_jn);
         b1_nsq_ff       <= PW'(n) * PW'(n);
         b1_ab_ff        <= u_ab;
         b1_nn_ff        <= PW'(u_na) * PW'(u_nb);
         b1_anb_ff       <= PW'(u_a) * PW'(u_nb);
         b1_nab_ff       <= PW'(u_na) * PW'(u_b);
         b1_va_ff        <= PW'(u_a) * PW'(u_na);
         b1_vb_ff        <= PW'(u_b) * PW'(u_nb);

         b2_tag_ff  <= b1_tag_ff;
         b2_mag_ff  <= b1_mag_ff;
         b2_nsq_ff  <= b1_nsq_ff;
         b2_dmax_ff <= (dp_x < dp_y) ? dp_x : dp_y;
         b2_mll_ff  <= PW'(b1_mag_ff[CW-1:0]) * PW'(b1_mag_ff[CW-1:0]);
         b2_mlh_ff  <= PW'(b1_mag_ff[CW-1:0]) * PW'(b1_mag_ff[PW-1:CW]);
         b2_mhh_ff  <= PW'(b1_mag_ff[PW-1:CW]) * PW'(b1_mag_ff[PW-1:CW]);
         b2_vll_ff  <= PW'(b1_va_ff[CW-1:0]) * PW'(b1_vb_ff[CW-1:0]);
         b2_vlh_ff  <= PW'(b1_va_ff[CW-1:0]) * PW'(b1_vb_ff[PW-1:CW]);
         b2_vhl_ff  <= PW'(b1_va_ff[PW-1:CW]) * PW'(b1_vb_ff[CW-1:0]);
         b2_vhh_ff  <= PW'(b1_va_ff[PW-1:CW]) * PW'(b1_vb_ff[PW-1:CW]);

         b3_tag_ff  <= b2_tag_ff;
         b3_mag_ff  <= b2_mag_ff;
         b3_nsq_ff  <= b2_nsq_ff;
         b3_dmax_ff <= b2_dmax_ff;
         b3_msq_ff  <= {b2_mhh_ff, b2_mll_ff} + (ZW'(b2_mlh_ff) << (CW + 1));
         b3_den_ff  <= {b2_vhh_ff, b2_vll_ff}
                       + ((ZW'(b2_vlh_ff) + ZW'(b2_vhl_ff)) << CW);

         div_tag_ff[0] <= b3_tag_ff;
         for (int i = 1; i < QUOT_BITS; i++) begin
            div_tag_ff[i] <= div_tag_ff[i-1];
         end

         out_keep_ff  <= div_tag_ff[QUOT_BITS-1].pass
                         && !((cfg.min_r2 != '0) && (r2_res < cfg.min_r2));
         out_degen_ff <= div_tag_ff[QUOT_BITS-1].degen;
         out_r2_ff    <= r2_res;
         if (div_tag_ff[QUOT_BITS-1].degen) begin
            out_d_ff  <= '0;
            out_dp_ff <= '0;
         end else if (div_tag_ff[QUOT_BITS-1].neg) begin
            out_d_ff  <= 16'(-d_sat);
            out_dp_ff <= -dp_sat;
         end else begin
            out_d_ff  <= d_sat[15:0];
            out_dp_ff <= dp_sat;
         end
      end
   end

   ldps_divider #(.NW(PW + FRAC_BITS), .DW(PW)) u_div_d (
      .clock  (clock),
      .enable (adv),
      .num    ({b3_mag_ff, FRAC_BITS'(0)}),
      .den    (b3_nsq_ff),
      .quo    (q_d)
   );

   ldps_divider #(.NW(PW + FRAC_BITS), .DW(PW)) u_div_dp (
      .clock  (clock),
      .enable (adv),
      .num    ({b3_mag_ff, FRAC_BITS'(0)}),
      .den    (b3_dmax_ff),
      .quo    (q_dp)
   );

   ldps_divider #(.NW(ZW + FRAC_BITS), .DW(ZW)) u_div_r2 (
      .clock  (clock),
      .enable (adv),
      .num    ({b3_msq_ff, FRAC_BITS'(0)}),
      .den    (b3_den_ff),
      .quo    (q_r2)
   );

   assign d_sat  = (q_d > D_LIMIT) ? D_LIMIT : q_d;
   assign dp_sat = (q_dp > Q_ONE) ? Q_ONE : q_dp;
   assign r2_sat = (q_r2 > Q_ONE) ? Q_ONE : q_r2;
   assign r2_res = div_tag_ff[QUOT_BITS-1].degen ? '0 : r2_sat[16:0];

   assign rsp_valid        = out_valid_ff;
   assign rsp_keep         = out_keep_ff;
   assign rsp_degenerate   = out_degen_ff;
   assign rsp_r2_value     = out_r2_ff;
   assign rsp_d_value      = out_d_ff;
   assign rsp_dprime_value = out_dp_ff;

endmodule

[design/linkage_disequilibrium_pair_stats_core.sv]
// Linkage disequilibrium statistics for one marker pair per transfer.
// The request channel (req_valid/req_ready) carries the joint alternate
// count, the two per-marker alternate counts and the marker and base-pair
// gaps. The response channel (rsp_valid/rsp_ready) returns the keep and
// degenerate flags with r2, D and D' in Q1.16, truncated toward zero.
// The user must write registers over the APB-style port only while no
// transfer is in flight; the block does not enforce it. pready is tied
// high and reads return the stored values. Throughput is one transfer per
// cycle while the response side is not stalled. Each response passes
// through the front register, the queue, the product stages and the 18
// one-bit stages of the pipelined dividers to the output register.
// Reset clears all valid state and loads num_haplotypes with one and every
// other register with zero. When the receiver holds rsp_ready low the back
// pipeline freezes; the two-entry queue between front and back keeps
// accepting requests until it and the front register fill, and then
// req_ready drops.
module linkage_disequilibrium_pair_stats_core #(
   parameter int COUNT_BITS = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [19:0]        req_joint_count,
   input  logic [19:0]        req_count_first,
   input  logic [19:0]        req_count_second,
   input  logic [23:0]        req_marker_gap,
   input  logic [30:0]        req_bp_gap,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_keep,
   output logic               rsp_degenerate,
   output logic [16:0]        rsp_r2_value,
   output logic signed [15:0] rsp_d_value,
   output logic signed [17:0] rsp_dprime_value,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import ldps_pkg::*;

   // Only the low COUNT_BITS bits of each count take part, capped at the port width.
   localparam int CW = (COUNT_BITS < FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
   localparam int IW = 2 + 8 * CW;

   cfg_type       cfg_ff;
   reg_index_type reg_idx;
   logic          cfg_write;

   logic          push_valid, push_ready, pop_valid, pop_ready;
   logic [IW-1:0] push_data, pop_data;

   assign pready    = 1'b1;
   assign reg_idx   = reg_index_type'(paddr[4:2]);
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{num_haplotypes: 20'd1, default: '0};
      end else if (cfg_write) begin
         unique case (reg_idx)
            REG_NUM_HAPLOTYPES: cfg_ff.num_haplotypes <= pwdata[19:0];
            REG_WINDOW_ENABLES: cfg_ff.window_enables <= pwdata[3:0];
            REG_MAX_MARKER_GAP: cfg_ff.max_marker_gap <= pwdata[23:0];
            REG_MAX_BP_GAP:     cfg_ff.max_bp_gap     <= pwdata[30:0];
            REG_MIN_MARKER_GAP: cfg_ff.min_marker_gap <= pwdata[23:0];
            REG_MIN_BP_GAP:     cfg_ff.min_bp_gap     <= pwdata[30:0];
            REG_MIN_R2:         cfg_ff.min_r2         <= pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_NUM_HAPLOTYPES: prdata = 32'(cfg_ff.num_haplotypes);
         REG_WINDOW_ENABLES: prdata = 32'(cfg_ff.window_enables);
         REG_MAX_MARKER_GAP: prdata = 32'(cfg_ff.max_marker_gap);
         REG_MAX_BP_GAP:     prdata = 32'(cfg_ff.max_bp_gap);
         REG_MIN_MARKER_GAP: prdata = 32'(cfg_ff.min_marker_gap);
         REG_MIN_BP_GAP:     prdata = 32'(cfg_ff.min_bp_gap);
         REG_MIN_R2:         prdata = 32'(cfg_ff.min_r2);
         default:            prdata = '0;
      endcase
   end

   // Front: window checks, monomorphic test and the first products.
   ldps_front #(.CW(CW)) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_joint_count  (req_joint_count),
      .req_count_first  (req_count_first),
      .req_count_second (req_count_second),
      .req_marker_gap   (req_marker_gap),
      .req_bp_gap       (req_bp_gap),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   ldps_queue #(.WIDTH(IW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back: wide products, three pipelined dividers and the output register.
   ldps_back #(.CW(CW)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_keep         (rsp_keep),
      .rsp_degenerate   (rsp_degenerate),
      .rsp_r2_value     (rsp_r2_value),
      .rsp_d_value      (rsp_d_value),
      .rsp_dprime_value (rsp_dprime_value)
   );

endmodule

[dv/linkage_disequilibrium_pair_stats_core_tb.sv]
module linkage_disequilibrium_pair_stats_core_tb;
   import ldps_pkg::*;

   // One marker pair as presented on the request channel.
   typedef struct {
      logic [19:0] joint;
      logic [19:0] cnt_a;
      logic [19:0] cnt_b;
      logic [23:0] mgap;
      logic [30:0] bgap;
   } pair_t;

   // The statistics that the block must return for one pair.
   typedef struct {
      logic               keep;
      logic               degen;
      logic [16:0]        r2;
      logic signed [15:0] d;
      logic signed [17:0] dprime;
   } stats_t;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [19:0]        req_joint_count;
   logic [19:0]        req_count_first;
   logic [19:0]        req_count_second;
   logic [23:0]        req_marker_gap;
   logic [30:0]        req_bp_gap;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_keep;
   logic               rsp_degenerate;
   logic [16:0]        rsp_r2_value;
   logic signed [15:0] rsp_d_value;
   logic signed [17:0] rsp_dprime_value;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [4:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   // The testbench copy of the register file, updated as each write lands.
   cfg_type cfg;

   pair_t  pending_pairs[$];
   stats_t expected_stats[$];

   int  send_wait;
   int  stall_wait;
   int  stall_draw;
   bit  no_idle;
   bit  failed;
   int  quiet_cycles;

   linkage_disequilibrium_pair_stats_core DUT (.*);

   // Clock with a 12 unit period.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Floor of x/y, held at limit. Any quotient beyond the 18 quotient bits
   // of the hardware divider is above every limit, so a plain clamp matches.
   function automatic logic [17:0] sat_quotient(logic [127:0] x, logic [127:0] y,
                                                logic [17:0] limit);
      logic [127:0] q;
      q = x / y;
      return (q > limit) ? limit : q[17:0];
   endfunction

   // Computes D, r2 and D' exactly from integer products and applies the
   // distance windows and the r2 threshold.
   function automatic stats_t ld_predict(pair_t p, cfg_type c);
      stats_t       s;
      logic [127:0] n, j, a, b, jn, ab, mag, num16, dmax, x, y;
      logic [17:0]  dq, dpq, r2q;
      logic         neg;
      logic         pass;
      n    = c.num_haplotypes;
      j    = p.joint;
      a    = p.cnt_a;
      b    = p.cnt_b;
      neg  = 1'b0;
      dq   = '0;
      dpq  = '0;
      r2q  = '0;
      pass = 1'b1;
      if (c.window_enables[WIN_MAX_MARKER] && p.mgap > c.max_marker_gap) pass = 1'b0;
      if (c.window_enables[WIN_MAX_BP] && p.bgap > c.max_bp_gap) pass = 1'b0;
      if (c.window_enables[WIN_MIN_MARKER] && p.mgap < c.min_marker_gap) pass = 1'b0;
      if (c.window_enables[WIN_MIN_BP] && p.bgap < c.min_bp_gap) pass = 1'b0;
      s.degen = (a == 0) || (a >= n) || (b == 0) || (b >= n);
      if (!s.degen) begin
         jn = j * n;
         ab = a * b;
         if (jn >= ab) begin
            mag = jn - ab;
         end else begin
            mag = ab - jn;
            neg = 1'b1;
         end
         num16 = mag << 16;
         dq = sat_quotient(num16, n * n, D_LIMIT);
         // Dmax depends on the sign of the numerator.
         if (neg) begin
            x = a * b;
            y = (n - a) * (n - b);
         end else begin
            x = a * (n - b);
            y = (n - a) * b;
         end
         dmax = (x < y) ? x : y;
         dpq = sat_quotient(num16, dmax, Q_ONE);
         r2q = sat_quotient((mag * mag) << 16, (a * (n - a)) * (b * (n - b)), Q_ONE);
      end
      if (c.min_r2 != 0 && {1'b0, r2q} < {1'b0, c.min_r2}) pass = 1'b0;
      s.keep   = pass;
      s.r2     = r2q[16:0];
      s.d      = neg ? -dq[15:0] : dq[15:0];
      s.dprime = neg ? -dpq : dpq;
      return s;
   endfunction

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 7);
   endfunction

   // Request driver. A new pair goes out as soon as the previous transfer
   // and its drawn gap are done; valid is only written once per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_stats.push_back(ld_predict('{req_joint_count, req_count_first,
               req_count_second, req_marker_gap, req_bp_gap}, cfg));
         end
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait <= send_wait - 1;
               req_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               pair_t nxt;
               nxt = pending_pairs.pop_front();
               req_valid        <= 1'b1;
               req_joint_count  <= nxt.joint;
               req_count_first  <= nxt.cnt_a;
               req_count_second <= nxt.cnt_b;
               req_marker_gap   <= nxt.mgap;
               req_bp_gap       <= nxt.bgap;
               send_wait        <= draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Each transfer is checked against the oldest
   // prediction, then a stall for the next one is drawn; a draw of zero
   // keeps ready high.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b1;
         stall_wait <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_stats.size() == 0) begin
               $display("%0t: response with nothing expected", $time);
               failed = 1'b1;
            end else begin
               stats_t e;
               e = expected_stats.pop_front();
               if (rsp_keep !== e.keep) begin
                  $display("%0t: keep expected %0d actual %0d", $time, e.keep, rsp_keep);
                  failed = 1'b1;
               end
               if (rsp_degenerate !== e.degen) begin
                  $display("%0t: degenerate expected %0d actual %0d", $time, e.degen,
                           rsp_degenerate);
                  failed = 1'b1;
               end
               if (rsp_r2_value !== e.r2) begin
                  $display("%0t: r2 expected %0d actual %0d", $time, e.r2, rsp_r2_value);
                  failed = 1'b1;
               end
               if (rsp_d_value !== e.d) begin
                  $display("%0t: D expected %0d actual %0d", $time, e.d, rsp_d_value);
                  failed = 1'b1;
               end
               if (rsp_dprime_value !== e.dprime) begin
                  $display("%0t: D' expected %0d actual %0d", $time, e.dprime,
                           rsp_dprime_value);
                  failed = 1'b1;
               end
            end
            stall_draw = draw_wait();
            if (stall_draw > 0) begin
               stall_wait <= stall_draw - 1;
               rsp_ready  <= 1'b0;
            end
         end else if (!rsp_ready) begin
            if (stall_wait > 0) stall_wait <= stall_wait - 1;
            else rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: too long without any transfer or register access ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= 5000) begin
            $display("linkage_disequilibrium_pair_stats_core: mismatch");
            $finish;
         end
      end
   end

   // Setup and access cycles of one register write.
   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_NUM_HAPLOTYPES: cfg.num_haplotypes = value[19:0];
         REG_WINDOW_ENABLES: cfg.window_enables = value[3:0];
         REG_MAX_MARKER_GAP: cfg.max_marker_gap = value[23:0];
         REG_MAX_BP_GAP:     cfg.max_bp_gap     = value[30:0];
         REG_MIN_MARKER_GAP: cfg.min_marker_gap = value[23:0];
         REG_MIN_BP_GAP:     cfg.min_bp_gap     = value[30:0];
         REG_MIN_R2:         cfg.min_r2         = value[16:0];
         default: ;
      endcase
   endtask

   task automatic add_pair(int j, int a, int b, int mg, int bg);
      pair_t p;
      p.joint = j[19:0];
      p.cnt_a = a[19:0];
      p.cnt_b = b[19:0];
      p.mgap  = mg[23:0];
      p.bgap  = bg[30:0];
      pending_pairs.push_back(p);
   endtask

   // Waits for every pair to go out and every response to return, then lets
   // the pipeline settle for about its latency.
   task automatic drain();
      while (pending_pairs.size() > 0 || req_valid || expected_stats.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Random gaps: half the time near the window settings, else anywhere.
   function automatic int rand_mgap();
      return $urandom_range(0, 1) ? $urandom_range(0, 64) : ($urandom & 32'hFFFFFF);
   endfunction

   function automatic int rand_bgap();
      return $urandom_range(0, 1) ? $urandom_range(0, 5000) : ($urandom & 32'h7FFFFFFF);
   endfunction

   // Mostly consistent counts; some degenerate and some arbitrary pairs.
   task automatic add_random_pair();
      int n, a, b, lo, hi, sel;
      n   = cfg.num_haplotypes;
      sel = $urandom_range(0, 9);
      if (sel == 0 || n < 2) begin
         add_pair($urandom, $urandom, $urandom, rand_mgap(), rand_bgap());
      end else if (sel == 1) begin
         a = $urandom_range(0, 1) ? 0 : $urandom_range(n, 1048575);
         b = $urandom_range(0, n);
         if ($urandom_range(0, 1)) add_pair($urandom_range(0, n), a, b, rand_mgap(), rand_bgap());
         else add_pair($urandom_range(0, n), b, a, rand_mgap(), rand_bgap());
      end else begin
         a  = $urandom_range(1, n - 1);
         b  = $urandom_range(1, n - 1);
         lo = (a + b > n) ? a + b - n : 0;
         hi = (a < b) ? a : b;
         add_pair($urandom_range(lo, hi), a, b, rand_mgap(), rand_bgap());
      end
   endtask

   initial begin
      int n, phase, k;
      failed    = 1'b0;
      no_idle   = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b1;
      req_joint_count  = '0;
      req_count_first  = '0;
      req_count_second = '0;
      req_marker_gap   = '0;
      req_bp_gap       = '0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      cfg = '{num_haplotypes: 20'd1, default: '0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // With the reset value of one haplotype every pair is degenerate.
      add_pair(0, 1, 1, 0, 0);
      add_pair(1048575, 1048575, 1048575, 16777215, 32'h7FFFFFFF);
      add_pair(0, 0, 0, 5, 5);
      drain();

      // Directed pairs around the edges of the statistics.
      write_reg(REG_NUM_HAPLOTYPES, 1000);
      add_pair(0, 0, 500, 1, 1);             // first marker monomorphic
      add_pair(0, 500, 1000, 1, 1);          // second marker fixed
      add_pair(0, 1200, 500, 1, 1);          // count above N
      add_pair(1, 1, 1, 1, 1);               // complete positive linkage
      add_pair(0, 1, 1, 1, 1);
      add_pair(0, 500, 500, 1, 1);           // negative D at its floor
      add_pair(500, 500, 500, 1, 1);         // D at its ceiling
      add_pair(250, 500, 500, 1, 1);         // independence
      add_pair(999, 999, 999, 1, 1);
      add_pair(0, 999, 1, 1, 1);
      add_pair(700, 300, 300, 1, 1);         // joint above both counts
      add_pair(1048575, 999, 999, 1, 1);
      add_pair(1, 999, 1, 16777215, 32'h7FFFFFFF);
      drain();
      write_reg(REG_NUM_HAPLOTYPES, 1048575);
      add_pair(1048574, 1048574, 1048574, 0, 0);
      add_pair(0, 1048574, 1048574, 0, 0);
      add_pair(0, 524287, 524288, 0, 0);
      add_pair(1048575, 1, 1, 0, 0);
      add_pair(1, 1, 1048574, 0, 0);
      drain();
      write_reg(REG_NUM_HAPLOTYPES, 2);
      add_pair(1, 1, 1, 3, 3);
      add_pair(0, 1, 1, 3, 3);
      add_pair(2, 1, 1, 3, 3);
      drain();

      // Random phases, each under its own register settings. The first and
      // last phases push the window and threshold registers to their limits.
      for (phase = 0; phase < 12; phase++) begin
         case ($urandom_range(0, 4))
            0: n = 2;
            1: n = $urandom_range(3, 40);
            2: n = $urandom_range(41, 5000);
            3: n = 1048575;
            default: n = $urandom_range(2, 1048575);
         endcase
         write_reg(REG_NUM_HAPLOTYPES, n);
         write_reg(REG_WINDOW_ENABLES, (phase == 0 || phase == 11) ? 15 : $urandom_range(0, 15));
         if (phase == 0) begin
            write_reg(REG_MAX_MARKER_GAP, 32'hFFFFFF);
            write_reg(REG_MAX_BP_GAP, 32'h7FFFFFFF);
            write_reg(REG_MIN_MARKER_GAP, 0);
            write_reg(REG_MIN_BP_GAP, 0);
            write_reg(REG_MIN_R2, 65536);
         end else if (phase == 11) begin
            write_reg(REG_MAX_MARKER_GAP, 0);
            write_reg(REG_MAX_BP_GAP, 0);
            write_reg(REG_MIN_MARKER_GAP, 32'hFFFFFF);
            write_reg(REG_MIN_BP_GAP, 32'h7FFFFFFF);
            write_reg(REG_MIN_R2, 131071);
         end else begin
            write_reg(REG_MAX_MARKER_GAP, $urandom_range(20, 64));
            write_reg(REG_MAX_BP_GAP, $urandom_range(2000, 5000));
            write_reg(REG_MIN_MARKER_GAP, $urandom_range(0, 20));
            write_reg(REG_MIN_BP_GAP, $urandom_range(0, 2000));
            write_reg(REG_MIN_R2, $urandom_range(0, 1) ? 0 : $urandom_range(1, 65536));
         end
         // Some phases run without any idling on either side.
         no_idle = (phase % 4 == 3);
         @(negedge clock);
         for (k = 0; k < 110; k++) add_random_pair();
         drain();
      end

      if (!failed) begin
         $display("linkage_disequilibrium_pair_stats_core: match");
      end else begin
         $display("linkage_disequilibrium_pair_stats_core: mismatch");
      end
      $finish;
   end

endmodule
